// ----- rtl/dht_pkg.sv -----
`timescale 1ns / 1ps
package dht_pkg;
  localparam int unsigned MaxSlots = 1024;
  localparam int unsigned SlotW = $clog2(MaxSlots);
  localparam int unsigned SizeW = 11;
  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned CntW = $clog2(MaxSlots + 1);

  localparam logic [1:0] StFound = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StInserted = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  typedef struct packed {
    logic load;
    logic div_start;
    logic probe_rd;
    logic step;
    logic write;
    logic clr_step;
  } dht_cmd_t;

  typedef struct packed {
    logic div_done;
    logic clr_done;
    logic slot_valid;
    logic key_match;
    logic exhausted;
  } dht_stat_t;
endpackage

// ----- rtl/dht_datapath.sv -----
`timescale 1ns / 1ps
module dht_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [dht_pkg::SizeW-1:0] table_size_i,
  input  logic [dht_pkg::KeyW-1:0]  key_i,
  input  logic [dht_pkg::ValW-1:0]  val_i,
  input  dht_pkg::dht_cmd_t         cmd_i,
  output dht_pkg::dht_stat_t        stat_o,
  output logic [dht_pkg::ValW-1:0]  rd_val_o
);
  import dht_pkg::*;

  logic [KeyW-1:0] key_q, val_q;
  logic [SizeW-1:0] m_q;
  logic [SizeW-1:0] rem1_q, rem2_q;
  logic [5:0] bit_q;
  logic div_busy_q;
  logic [SizeW-1:0] stride_q, slot_q;
  logic [CntW-1:0] cnt_q;
  logic [SlotW-1:0] clr_q;
  logic clr_done_q;
  logic used_mem [MaxSlots];
  logic [KeyW-1:0] kmem [MaxSlots];
  logic [ValW-1:0] vmem [MaxSlots];
  logic ru_q;
  logic [KeyW-1:0] rk_q;
  logic [ValW-1:0] rv_q;
  logic [SizeW-1:0] m_eff, m2;
  logic [SizeW:0] t1, t2, nxt;
  logic [SlotW-1:0] slot_idx;

  always_comb begin
    m_eff = table_size_i;
    if (table_size_i < SizeW'(3)) m_eff = SizeW'(3);
    if (table_size_i > SizeW'(MaxSlots)) m_eff = SizeW'(MaxSlots);
  end
  assign m2 = m_q - SizeW'(2);
  // restoring division, both moduli in parallel
  assign t1 = {rem1_q, key_q[bit_q[4:0]]};
  assign t2 = {rem2_q, key_q[bit_q[4:0]]};
  assign nxt = {1'b0, slot_q} + {1'b0, stride_q};
  assign slot_idx = (slot_q >= SizeW'(MaxSlots)) ? '0 : slot_q[SlotW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      bit_q <= '0;
      clr_done_q <= 1'b0;
      clr_q <= '0;
      cnt_q <= '0;
    end else begin
      // clearing pass, one slot per cycle
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + SlotW'(1);
        if (clr_q == '1) clr_done_q <= 1'b1;
      end
      if (cmd_i.div_start) begin
        div_busy_q <= 1'b1;
        bit_q <= 6'd31;
      end else if (div_busy_q) begin
        if (bit_q == '0) div_busy_q <= 1'b0;
        bit_q <= bit_q - 6'd1;
      end
      if (cmd_i.load) cnt_q <= '0;
      if (cmd_i.step) cnt_q <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i;
      val_q <= val_i;
      m_q <= m_eff;
      rem1_q <= '0;
      rem2_q <= '0;
    end
    if (div_busy_q) begin
      rem1_q <= (t1 >= {1'b0, m_q}) ? SizeW'(t1 - {1'b0, m_q}) : t1[SizeW-1:0];
      rem2_q <= (t2 >= {1'b0, m2}) ? SizeW'(t2 - {1'b0, m2}) : t2[SizeW-1:0];
      if (bit_q == '0) begin
        stride_q <= ((t2 >= {1'b0, m2}) ? SizeW'(t2 - {1'b0, m2}) : t2[SizeW-1:0])
                    + SizeW'(1);
        slot_q <= (t1 >= {1'b0, m_q}) ? SizeW'(t1 - {1'b0, m_q}) : t1[SizeW-1:0];
      end
    end
    if (cmd_i.step)
      slot_q <= (nxt >= {1'b0, m_q}) ? SizeW'(nxt - {1'b0, m_q}) : nxt[SizeW-1:0];
    if (cmd_i.clr_step) used_mem[clr_q] <= 1'b0;
    if (cmd_i.probe_rd) begin
      ru_q <= used_mem[slot_idx];
      rk_q <= kmem[slot_idx];
      rv_q <= vmem[slot_idx];
    end
    if (cmd_i.write) begin
      used_mem[slot_idx] <= 1'b1;
      kmem[slot_idx] <= key_q;
      vmem[slot_idx] <= val_q;
    end
  end

  assign stat_o.div_done = div_busy_q && (bit_q == '0);
  assign stat_o.clr_done = clr_done_q;
  assign stat_o.slot_valid = ru_q;
  assign stat_o.key_match = (rk_q == key_q);
  assign stat_o.exhausted = (cnt_q >= CntW'(m_q));
  assign rd_val_o = rv_q;
endmodule

// ----- rtl/dht_ctrl.sv -----
`timescale 1ns / 1ps
module dht_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    cmd_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic [dht_pkg::ValW-1:0] found_value_o,
  input  logic [dht_pkg::ValW-1:0] rd_val_i,
  input  dht_pkg::dht_stat_t      stat_i,
  output dht_pkg::dht_cmd_t       cmd_o
);
  import dht_pkg::*;

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle = 3'd1;
  localparam logic [2:0] SDiv = 3'd2;
  localparam logic [2:0] SCheck = 3'd3;
  localparam logic [2:0] SRead = 3'd4;

  logic [2:0] state_q, state_d;
  logic enter_q, ovalid_q, ovalid_d;
  logic [1:0] status_q, status_d;
  logic [ValW-1:0] fval_q, fval_d;
  logic accept;

  assign in_stall_o = (state_q != SIdle) || (ovalid_q && out_stall_i);
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    ovalid_d = ovalid_q && out_stall_i;
    status_d = status_q;
    fval_d = fval_q;
    case (state_q)
      SClear: begin
        cmd_o.clr_step = !stat_i.clr_done;
        if (stat_i.clr_done) state_d = SIdle;
      end
      SIdle: if (accept) begin
        cmd_o.load = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = SDiv;
      end
      SDiv: if (stat_i.div_done) state_d = SCheck;
      SCheck: begin
        if (stat_i.exhausted) begin
          ovalid_d = 1'b1; status_d = StFull; fval_d = '0; state_d = SIdle;
        end else begin
          cmd_o.probe_rd = 1'b1;
          state_d = SRead;
        end
      end
      SRead: begin
        if (!stat_i.slot_valid) begin
          ovalid_d = 1'b1; fval_d = '0; state_d = SIdle;
          status_d = enter_q ? StInserted : StMiss;
          cmd_o.write = enter_q;
        end else if (stat_i.key_match) begin
          ovalid_d = 1'b1; status_d = StFound; fval_d = rd_val_i; state_d = SIdle;
        end else begin
          cmd_o.step = 1'b1;
          state_d = SCheck;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      ovalid_q <= 1'b0;
      enter_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
      if (accept) enter_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    fval_q <= fval_d;
  end

  assign out_valid_o = ovalid_q;
  assign status_o = status_q;
  assign found_value_o = fval_q;

  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> state_q == SIdle) else $error("accept outside idle");
  a_write_only_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write |-> enter_q) else $error("write on find");
  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle && state_d == SIdle && state_q != SClear) |=> ovalid_q)
    else $error("lost result");
endmodule

// ----- rtl/double_hash_table_find_insert.sv -----
`timescale 1ns / 1ps
// channel  valid       stall        payload
// in       in_valid_i  in_stall_o   cmd_i lookup_key_i store_value_i
// out      out_valid_o out_stall_i  status_o found_value_o
// cfg      cfg_we_i    -            cfg_wdata_i (table_size)
// one item at a time: an accept, then both moduli from the bit-serial divider,
// then a check state and a read state per probe; a full table ends after m probes plus one check
// the result word is registered and presented once the last probe or check decides it
// after reset a clearing pass empties all slots before items are taken
// a result waiting under stall holds back the next input word
module double_hash_table_find_insert (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [dht_pkg::SizeW-1:0] cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic cmd_i,
  input  logic [dht_pkg::KeyW-1:0] lookup_key_i,
  input  logic [dht_pkg::ValW-1:0] store_value_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic [1:0] status_o,
  output logic [dht_pkg::ValW-1:0] found_value_o
);
  import dht_pkg::*;

  logic [SizeW-1:0] size_q;
  dht_cmd_t cmd;
  dht_stat_t stat;
  logic [ValW-1:0] rd_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= SizeW'(1021);
    else if (cfg_we_i) size_q <= cfg_wdata_i;
  end

  dht_datapath u_dp (
    .clk_i, .rst_ni, .table_size_i(size_q), .key_i(lookup_key_i),
    .val_i(store_value_i), .cmd_i(cmd), .stat_o(stat), .rd_val_o(rd_val)
  );

  dht_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .out_valid_o,
    .out_stall_i, .status_o, .found_value_o, .rd_val_i(rd_val),
    .stat_i(stat), .cmd_o(cmd)
  );
endmodule
